### rtl/core/uule_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// uule_pkg
// Shared types, codes and the 6-bit character mapping of the line encoder.
// ---------------------------------------------------------------------------
package uule_pkg;

	localparam logic OP_DATA   = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	localparam logic [7:0] CHAR_CR  = 8'h0D;
	localparam logic [7:0] CHAR_LF  = 8'h0A;
	localparam logic [7:0] CHAR_PAD = 8'h60;
	localparam logic [7:0] CHAR_OFS = 8'h20;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LEN,
		S_RD0,
		S_RD1,
		S_RD2,
		S_RD3,
		S_CHR,
		S_CR,
		S_LF
	} uule_state_t;

	typedef enum logic [1:0] {
		CSEL_LEN,
		CSEL_DATA,
		CSEL_CR,
		CSEL_LF
	} uule_csel_t;

	typedef struct packed {
		logic       wr_byte;
		logic       start_line;
		logic       rd_en;
		logic [1:0] rd_off;
		logic       cap0;
		logic       cap1;
		logic       cap2;
		logic       ch_clr;
		logic       ch_inc;
		logic       next_group;
		logic       emit;
		uule_csel_t csel;
	} uule_cmd_t;

	typedef struct packed {
		logic count_zero;
		logic count_last;
		logic last_group;
		logic ch_last;
		logic out_free;
	} uule_sts_t;

	function automatic logic [7:0] code6(input logic [5:0] v);
		logic [7:0] r;
		if (v == 6'd0) begin
			r = CHAR_PAD;
		end else begin
			r = {2'b00, v} + CHAR_OFS;
		end
		return r;
	endfunction

endpackage

### rtl/core/uuencode_line_encoder_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// uuencode_line_encoder_core
// Collects raw bytes and emits uuencoded text lines with CR and LF.
// ---------------------------------------------------------------------------
// Channel  Direction  Handshake            Payload
// in       input      in_valid, in_stall   operation, data_byte
// out      output     out_valid, out_stall out_char, last_of_run
//
// A data byte that does not complete a line is accepted without raising in_stall.
// A line is emitted as its length character, then per group a read on the
// single line store read port (states S_RD0 to S_RD3) and four characters on
// the one-character output register, then CR and LF.
// in_stall is high while a line is being emitted; out_stall holds the line.
// Reset clears the byte count and all control state; the store is not cleared.
// ---------------------------------------------------------------------------
module uuencode_line_encoder_core import uule_pkg::*; #(
	parameter int LINE_BYTES = 45
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       operation,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_char,
	output logic       last_of_run
);

	uule_cmd_t cmd;
	uule_sts_t sts;

	uule_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.operation(operation),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	uule_dp #(
		.LINE_BYTES(LINE_BYTES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.data_byte  (data_byte),
		.cmd        (cmd),
		.sts        (sts),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.out_char   (out_char),
		.last_of_run(last_of_run)
	);

endmodule

### rtl/core/uule_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// uule_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module uule_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 45
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/core/uule_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// uule_ctrl
// Sequencer that collects bytes and walks a line out group by group.
// ---------------------------------------------------------------------------
module uule_ctrl import uule_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      operation,
	output logic      in_stall,
	input  uule_sts_t sts,
	output uule_cmd_t cmd
);

	uule_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (operation == OP_DATA) begin
						if (sts.count_last) begin
							state_d = S_LEN;
						end
					end else if (!sts.count_zero) begin
						state_d = S_LEN;
					end
				end
			end
			S_LEN: begin
				if (sts.out_free) begin
					state_d = S_RD0;
				end
			end
			S_RD0: state_d = S_RD1;
			S_RD1: state_d = S_RD2;
			S_RD2: state_d = S_RD3;
			S_RD3: state_d = S_CHR;
			S_CHR: begin
				if (sts.out_free && sts.ch_last) begin
					state_d = sts.last_group ? S_CR : S_RD0;
				end
			end
			S_CR: begin
				if (sts.out_free) begin
					state_d = S_LF;
				end
			end
			S_LF: begin
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.csel = CSEL_LEN;
		in_stall = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (operation == OP_DATA) begin
						cmd.wr_byte    = 1'b1;
						cmd.start_line = sts.count_last;
					end else begin
						cmd.start_line = !sts.count_zero;
					end
				end
			end
			S_LEN: begin
				cmd.emit = sts.out_free;
				cmd.csel = CSEL_LEN;
			end
			S_RD0: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_off = 2'd0;
				cmd.ch_clr = 1'b1;
			end
			S_RD1: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_off = 2'd1;
				cmd.cap0   = 1'b1;
			end
			S_RD2: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_off = 2'd2;
				cmd.cap1   = 1'b1;
			end
			S_RD3: begin
				cmd.cap2 = 1'b1;
			end
			S_CHR: begin
				cmd.emit       = sts.out_free;
				cmd.csel       = CSEL_DATA;
				cmd.ch_inc     = sts.out_free;
				cmd.next_group = sts.out_free && sts.ch_last && !sts.last_group;
			end
			S_CR: begin
				cmd.emit = sts.out_free;
				cmd.csel = CSEL_CR;
			end
			S_LF: begin
				cmd.emit = sts.out_free;
				cmd.csel = CSEL_LF;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

### rtl/core/uule_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// uule_dp
// Line store, counters, group registers and the output register.
// ---------------------------------------------------------------------------
module uule_dp import uule_pkg::*; #(
	parameter int LINE_BYTES = 45
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] data_byte,
	input  uule_cmd_t  cmd,
	output uule_sts_t  sts,
	input  logic       out_stall,
	output logic       out_valid,
	output logic [7:0] out_char,
	output logic       last_of_run
);

	localparam int CW = $clog2(LINE_BYTES + 1);
	localparam int AW = $clog2(LINE_BYTES);

	logic [CW-1:0] count_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] gidx_q;
	logic [1:0]    ch_idx_q;
	logic [7:0]    b0_q, b1_q, b2_q;
	logic [7:0]    rdata;
	logic [CW:0]   rsum;
	logic          keep1, keep2;
	logic [7:0]    data_char;
	logic [7:0]    char_d;
	logic          out_valid_q;
	logic [7:0]    out_char_q;
	logic          last_q;

	uule_ram #(
		.WIDTH(8),
		.DEPTH(LINE_BYTES)
	) u_store (
		.clk  (clk),
		.we   (cmd.wr_byte),
		.waddr(count_q[AW-1:0]),
		.wdata(data_byte),
		.re   (cmd.rd_en),
		.raddr(rsum[AW-1:0]),
		.rdata(rdata)
	);

	assign rsum  = {1'b0, gidx_q} + {{(CW-1){1'b0}}, cmd.rd_off};
	assign keep1 = ({1'b0, gidx_q} + (CW+1)'(1)) < {1'b0, n_q};
	assign keep2 = ({1'b0, gidx_q} + (CW+1)'(2)) < {1'b0, n_q};

	assign sts.count_zero = (count_q == '0);
	assign sts.count_last = (count_q == CW'(LINE_BYTES - 1));
	assign sts.last_group = (({1'b0, gidx_q} + (CW+1)'(3)) >= {1'b0, n_q});
	assign sts.ch_last    = (ch_idx_q == 2'd3);
	assign sts.out_free   = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			n_q      <= '0;
			gidx_q   <= '0;
			ch_idx_q <= '0;
		end else begin
			if (cmd.start_line) begin
				n_q     <= cmd.wr_byte ? count_q + CW'(1) : count_q;
				count_q <= '0;
				gidx_q  <= '0;
			end else begin
				if (cmd.wr_byte) begin
					count_q <= count_q + CW'(1);
				end
				if (cmd.next_group) begin
					gidx_q <= gidx_q + CW'(3);
				end
			end
			if (cmd.ch_clr) begin
				ch_idx_q <= '0;
			end else if (cmd.ch_inc) begin
				ch_idx_q <= ch_idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap0) begin
			b0_q <= rdata;
		end
		if (cmd.cap1) begin
			b1_q <= keep1 ? rdata : 8'h00;
		end
		if (cmd.cap2) begin
			b2_q <= keep2 ? rdata : 8'h00;
		end
	end

	always_comb begin
		case (ch_idx_q)
			2'd0:    data_char = code6(b0_q[7:2]);
			2'd1:    data_char = code6({b0_q[1:0], b1_q[7:4]});
			2'd2:    data_char = code6({b1_q[3:0], b2_q[7:6]});
			default: data_char = code6(b2_q[5:0]);
		endcase
	end

	always_comb begin
		case (cmd.csel)
			CSEL_LEN:  char_d = code6(6'(n_q));
			CSEL_DATA: char_d = data_char;
			CSEL_CR:   char_d = CHAR_CR;
			CSEL_LF:   char_d = CHAR_LF;
			default:   char_d = CHAR_LF;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_char_q <= char_d;
			last_q     <= (cmd.csel == CSEL_LF);
		end
	end

	assign out_valid   = out_valid_q;
	assign out_char    = out_char_q;
	assign last_of_run = last_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q < CW'(LINE_BYTES))
		else $error("byte count reached the line length");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || !out_stall))
		else $error("character loaded over a stalled transaction");

	a_last_is_lf: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && last_q) |-> (out_char_q == CHAR_LF))
		else $error("end of line flag on a character other than LF");

	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_line |=> (count_q == '0) && (gidx_q == '0))
		else $error("line start did not clear the counters");

endmodule
